>>> rtl/core/nae_pkg.sv
// Shared types and constants for the NAL to Annex B escaper.
package nae_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAX_OUT = 8;
  localparam int unsigned LA_DEPTH = 4;
  localparam int unsigned IDX_W = $clog2(MAX_OUT);

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS = 5'd8;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE = 8'h01;
  localparam logic [BYTE_W-1:0] EMU_PREVENT = 8'h03;
  localparam logic [BYTE_W-1:0] ESC_LIMIT = 8'h03;

  // One queued request: the output bytes that one input byte produced.
  typedef struct packed {
    logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
    logic [IDX_W-1:0]               last_idx;
    logic                           unit_end;
  } rec_t;

endpackage

>>> rtl/core/nal_to_annexb_escaper_unit.sv
// Top level of the NAL unit to Annex B byte stream escaper.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------------
//  s_axis   | in  | tvalid/tready        | tdata: in_byte; tuser: unit_first, frame_first;
//           |     |                      | tlast: unit_last
//  m_axis   | out | tvalid/tready        | tdata: out_byte, out_run_last; tlast: out_unit_end
//
//  One input byte is taken per cycle while the request queue has room; it
//  yields 0 to 8 output bytes, bundled into one queue request.
//  The serializer drains one output byte per cycle while m_axis_tready is high;
//  the first byte of a request goes through a queue slot and then the output register.
//  Sustained input rate is limited by output bytes.
//  Input stalls only when QUEUE_DEPTH requests are waiting; the output
//  register holds its byte while m_axis_tready is low.
//  Reset clears unit state, the queue and the output register.
module nal_to_annexb_escaper_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic [1:0]  s_axis_tuser,  // [0] unit_first, [1] frame_first
  input  logic        s_axis_tlast,  // unit_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] out_run_last, [15:9] zero
  output logic        m_axis_tlast   // out_unit_end
);

  logic          take;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          head_valid;
  nae_pkg::rec_t wr_rec;
  nae_pkg::rec_t head;
  logic [7:0]    out_byte;
  logic          out_run_last;

  // Accept a request whenever the queue can take one more.
  assign s_axis_tready = !q_full;
  assign take = s_axis_tvalid && s_axis_tready;

  nae_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .in_byte     (s_axis_tdata),
    .unit_first  (s_axis_tuser[0]),
    .unit_last   (s_axis_tlast),
    .frame_first (s_axis_tuser[1]),
    .push        (push),
    .rec         (wr_rec)
  );

  nae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_rec     (wr_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  nae_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_byte     (out_byte),
    .out_unit_end (m_axis_tlast),
    .out_run_last (out_run_last)
  );

  assign m_axis_tdata = {7'd0, out_run_last, out_byte};

  // A unit always ends on the last byte of a request.
  a_unit_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> out_run_last)
    else $error("unit end without run end");

  // Never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // Never retire a request that is not there.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue underflow");

  // The output register starts empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

>>> rtl/core/nae_front.sv
// Front end: start code detection, header insertion and escape scanning.
module nae_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [nae_pkg::BYTE_W-1:0] in_byte,
  input  logic                       unit_first,
  input  logic                       unit_last,
  input  logic                       frame_first,
  output logic                       push,
  output nae_pkg::rec_t              rec
);

  logic [nae_pkg::LA_DEPTH-1:0][nae_pkg::BYTE_W-1:0] la, la_next;
  logic [2:0] pending, pending_next;
  logic [2:0] seen, seen_next;
  logic       pass, pass_next;
  logic       hdr_done, hdr_done_next;
  logic       extra_zero, extra_zero_next;
  logic [nae_pkg::MAX_OUT-1:0][nae_pkg::BYTE_W-1:0] ob;
  logic [3:0] n;

  always_comb begin
    la_next = la;
    pending_next = pending;
    seen_next = seen;
    pass_next = pass;
    hdr_done_next = hdr_done;
    extra_zero_next = extra_zero;
    ob = '0;
    n = 4'd0;

    // Open a new unit on a marked first byte or when none is open.
    if (unit_first || seen == 3'd0) begin
      pending_next = 3'd0;
      seen_next = 3'd0;
      pass_next = 1'b0;
      hdr_done_next = 1'b0;
      extra_zero_next = frame_first || in_byte[4:0] == nae_pkg::NAL_TYPE_SPS ||
                        in_byte[4:0] == nae_pkg::NAL_TYPE_PPS;
    end

    if (pass_next) begin
      ob[n[2:0]] = in_byte; n = n + 4'd1;
    end else if (!hdr_done_next) begin
      la_next[seen_next[1:0]] = in_byte;
      seen_next = seen_next + 3'd1;
      pending_next = seen_next;
      if (seen_next == 3'd4 && la_next[0] == nae_pkg::BYTE_ZERO &&
          la_next[1] == nae_pkg::BYTE_ZERO && la_next[2] == nae_pkg::BYTE_ZERO &&
          la_next[3] == nae_pkg::BYTE_ONE) begin
        pass_next = 1'b1;
        ob[0] = la_next[0];
        ob[1] = la_next[1];
        ob[2] = la_next[2];
        ob[3] = la_next[3];
        n = 4'd4;
        pending_next = 3'd0;
      end else if (seen_next == 3'd4 || unit_last) begin
        if (extra_zero_next) begin
          ob[n[2:0]] = nae_pkg::BYTE_ZERO; n = n + 4'd1;
        end
        ob[n[2:0]] = nae_pkg::BYTE_ZERO; n = n + 4'd1;
        ob[n[2:0]] = nae_pkg::BYTE_ZERO; n = n + 4'd1;
        ob[n[2:0]] = nae_pkg::BYTE_ONE;  n = n + 4'd1;
        ob[n[2:0]] = la_next[0];         n = n + 4'd1;
        la_next[0] = la_next[1];
        la_next[1] = la_next[2];
        la_next[2] = la_next[3];
        pending_next = seen_next - 3'd1;
        hdr_done_next = 1'b1;
        extra_zero_next = 1'b0;
      end
    end else begin
      la_next[pending_next[1:0]] = in_byte;
      pending_next = pending_next + 3'd1;
      if (pending_next == 3'd4) begin
        if (la_next[0] == nae_pkg::BYTE_ZERO && la_next[1] == nae_pkg::BYTE_ZERO &&
            la_next[2] < nae_pkg::ESC_LIMIT) begin
          ob[0] = nae_pkg::BYTE_ZERO;
          ob[1] = nae_pkg::BYTE_ZERO;
          ob[2] = nae_pkg::EMU_PREVENT;
          ob[3] = la_next[2];
          n = 4'd4;
          la_next[0] = la_next[3];
          pending_next = 3'd1;
        end else begin
          ob[0] = la_next[0];
          n = 4'd1;
          la_next[0] = la_next[1];
          la_next[1] = la_next[2];
          la_next[2] = la_next[3];
          pending_next = 3'd3;
        end
      end
    end

    // Flush the held tail once on the last byte and close the unit.
    if (unit_last) begin
      if (hdr_done_next) begin
        for (int i = 0; i < nae_pkg::LA_DEPTH; i++) begin
          if (3'(i) < pending_next) begin
            ob[n[2:0]] = la_next[2'(i)]; n = n + 4'd1;
          end
        end
      end
      pending_next = 3'd0;
      seen_next = 3'd0;
      pass_next = 1'b0;
      hdr_done_next = 1'b0;
      extra_zero_next = 1'b0;
    end
  end

  assign push = take && n != 4'd0;
  assign rec.bytes = ob;
  assign rec.last_idx = nae_pkg::IDX_W'(n - 4'd1);
  assign rec.unit_end = unit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      seen <= '0;
      pass <= 1'b0;
      hdr_done <= 1'b0;
      extra_zero <= 1'b0;
    end else if (take) begin
      pending <= pending_next;
      seen <= seen_next;
      pass <= pass_next;
      hdr_done <= hdr_done_next;
      extra_zero <= extra_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      la <= la_next;
    end
  end

endmodule

>>> rtl/core/nae_queue.sv
// Small request queue between front end and serializer.
module nae_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nae_pkg::rec_t wr_rec,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output nae_pkg::rec_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  nae_pkg::rec_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/nae_back.sv
// Back end: serialize queued requests into a registered byte stream.
module nae_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  nae_pkg::rec_t              head,
  output logic                       pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [nae_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_unit_end,
  output logic                       out_run_last
);

  logic [nae_pkg::IDX_W-1:0] pos;
  logic load;
  logic at_end;

  assign load = !out_valid || out_ready;
  assign at_end = pos == head.last_idx;
  assign pop = load && head_valid && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        pos <= at_end ? '0 : pos + nae_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= head.bytes[pos];
      out_run_last <= at_end;
      out_unit_end <= at_end && head.unit_end;
    end
  end

endmodule

>>> sim/tb_nal_to_annexb_escaper_unit.sv
// Self-checking testbench for the NAL unit to Annex B escaper with its own byte predictor.
`timescale 1ns / 1ps

module tb_nal_to_annexb_escaper_unit;

  // One expected output byte of the Annex B stream.
  typedef struct {
    logic [7:0] data;
    logic       unit_end;
    logic       run_last;
  } annexb_beat_t;

  // How the downstream side throttles m_axis_tready.
  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN,
    STALL_HEAVY
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Expected Annex B bytes, oldest first.
  annexb_beat_t annexb_q[$];
  annexb_beat_t annexb_head;

  // Predictor copy of the unit state.
  logic [7:0] la_buf[nae_pkg::LA_DEPTH];
  logic [2:0] la_held;
  logic [2:0] unit_seen;
  bit         pass_mode;
  bit         hdr_sent;
  bit         lead_zero;

  // Bytes of the unit that a test is about to send.
  logic [7:0] unit_buf[$];

  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned burst_left;
  bit          gaps_on;
  stall_mode_t stall_mode;
  int unsigned hold_req;
  int unsigned hold_left;
  int unsigned stall_tick;

  nal_to_annexb_escaper_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Drive every input to a known value before the first edge.
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b1;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic clear_unit_state();
    la_held   = '0;
    unit_seen = '0;
    pass_mode = 1'b0;
    hdr_sent  = 1'b0;
    lead_zero = 1'b0;
  endtask

  // Drop k bytes from the front of the lookahead window.
  task automatic la_drop(input int unsigned k);
    int unsigned i;
    if (k >= la_held) begin
      la_held = '0;
    end else begin
      for (i = 0; i + k < la_held; i++) la_buf[i] = la_buf[i + k];
      la_held = la_held - k;
    end
  endtask

  // Work out the Annex B bytes one accepted request produces and queue them.
  task automatic predict_annexb(input logic [7:0] b, input bit first, input bit last,
                                input bit ff);
    logic [7:0]   res[$];
    logic [4:0]   nal_type;
    annexb_beat_t beat;
    int unsigned  i;
    int unsigned  n;
    // A marked first byte, or any byte with no unit open, starts a fresh unit.
    if (first || unit_seen == 0) begin
      nal_type = b[4:0];
      clear_unit_state();
      lead_zero = ff || nal_type == nae_pkg::NAL_TYPE_SPS ||
                  nal_type == nae_pkg::NAL_TYPE_PPS;
    end
    if (pass_mode) begin
      res.push_back(b);
    end else if (!hdr_sent) begin
      la_buf[unit_seen % nae_pkg::LA_DEPTH] = b;
      unit_seen++;
      la_held = unit_seen;
      if (unit_seen == 4 && la_buf[0] == nae_pkg::BYTE_ZERO &&
          la_buf[1] == nae_pkg::BYTE_ZERO && la_buf[2] == nae_pkg::BYTE_ZERO &&
          la_buf[3] == nae_pkg::BYTE_ONE) begin
        // Unit already carries a start code: forward it untouched.
        pass_mode = 1'b1;
        for (i = 0; i < 4; i++) res.push_back(la_buf[i]);
        la_held = '0;
      end else if (unit_seen == 4 || last) begin
        if (lead_zero) res.push_back(nae_pkg::BYTE_ZERO);
        res.push_back(nae_pkg::BYTE_ZERO);
        res.push_back(nae_pkg::BYTE_ZERO);
        res.push_back(nae_pkg::BYTE_ONE);
        res.push_back(la_buf[0]);
        la_drop(1);
        hdr_sent  = 1'b1;
        lead_zero = 1'b0;
      end
    end else begin
      la_buf[la_held % nae_pkg::LA_DEPTH] = b;
      if (la_held < 4) la_held++;
      if (la_held == 4) begin
        if (la_buf[0] == nae_pkg::BYTE_ZERO && la_buf[1] == nae_pkg::BYTE_ZERO &&
            la_buf[2] < nae_pkg::ESC_LIMIT) begin
          res.push_back(nae_pkg::BYTE_ZERO);
          res.push_back(nae_pkg::BYTE_ZERO);
          res.push_back(nae_pkg::EMU_PREVENT);
          res.push_back(la_buf[2]);
          la_drop(3);
        end else begin
          res.push_back(la_buf[0]);
          la_drop(1);
        end
      end
    end
    if (last) begin
      // Flush the tail raw, each byte exactly once.
      if (hdr_sent) begin
        for (i = 0; i < la_held && i < nae_pkg::LA_DEPTH; i++) res.push_back(la_buf[i]);
      end
      clear_unit_state();
    end
    n = (res.size() > nae_pkg::MAX_OUT) ? nae_pkg::MAX_OUT : res.size();
    for (i = 0; i < n; i++) begin
      beat.data     = res[i];
      beat.run_last = (i == n - 1);
      beat.unit_end = last && (i == n - 1);
      annexb_q.push_back(beat);
    end
  endtask

  // Offer one request and hold it until accepted; bursts end in random gaps when gaps_on is set.
  task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                           input bit ff);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = $urandom_range(1, 5);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = {ff, first};
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_annexb(b, first, last, ff);
    bytes_sent++;
  endtask

  // Send unit_buf as one unit; frame_first only matters on the opening byte.
  task automatic send_unit(input bit mark_first, input bit with_last, input bit ff);
    int unsigned i;
    for (i = 0; i < unit_buf.size(); i++) begin
      send_byte(unit_buf[i], mark_first && i == 0, with_last && i == unit_buf.size() - 1,
                (i == 0) ? ff : 1'($urandom));
    end
  endtask

  // Lower valid and wait until every expected byte has come out.
  task automatic wait_stream_drained();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (annexb_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  // Body bytes lean hard on zero so that escape patterns show up often.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return nae_pkg::BYTE_ZERO;
      5:             return 8'($urandom_range(1, 3));
      default:       return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] header_byte();
    case ($urandom_range(0, 9))
      0:       return {3'($urandom), nae_pkg::NAL_TYPE_SPS};
      1:       return {3'($urandom), nae_pkg::NAL_TYPE_PPS};
      default: return 8'($urandom);
    endcase
  endfunction

  // Downstream stall: a one-shot long hold takes priority over the pattern.
  always @(negedge clk) begin
    stall_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_NONE:    m_axis_tready = 1'b1;
        STALL_RANDOM:  m_axis_tready = ($urandom_range(0, 2) != 0);
        STALL_PATTERN: m_axis_tready = ((stall_tick % 7) >= 2);
        default:       m_axis_tready = ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Compare every delivered byte with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (annexb_q.size() == 0) begin
        report_mismatch("output byte with nothing expected", m_axis_tdata, '0);
      end else begin
        annexb_head = annexb_q.pop_front();
        if (m_axis_tdata[7:0] !== annexb_head.data)
          report_mismatch("out_byte", m_axis_tdata[7:0], annexb_head.data);
        if (m_axis_tdata[8] !== annexb_head.run_last)
          report_mismatch("out_run_last", m_axis_tdata[8], annexb_head.run_last);
        if (m_axis_tdata[15:9] !== 7'd0)
          report_mismatch("tdata pad bits", m_axis_tdata[15:9], '0);
        if (m_axis_tlast !== annexb_head.unit_end)
          report_mismatch("out_unit_end", m_axis_tlast, annexb_head.unit_end);
      end
    end
  end

  // Leading zero for frame start, SPS and a single-byte PPS unit.
  task automatic test_start_codes();
    gaps_on    = 1'b1;
    stall_mode = STALL_RANDOM;
    unit_buf = '{8'h65, 8'hAA, 8'hBB, 8'hCC};
    send_unit(1'b1, 1'b1, 1'b1);
    unit_buf = '{8'h67, 8'h42, 8'h00};
    send_unit(1'b1, 1'b1, 1'b0);
    unit_buf = '{8'h68};
    send_unit(1'b1, 1'b1, 1'b0);
  endtask

  // A unit that opens with 00 00 00 01 goes through as is; a short one never does.
  task automatic test_passthrough();
    stall_mode = STALL_PATTERN;
    unit_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_unit(1'b1, 1'b1, 1'b1);
    unit_buf = '{8'h00, 8'h00, 8'h00};
    send_unit(1'b1, 1'b1, 1'b0);
  endtask

  // An interior escape with 00 00 01 left raw in the tail, then an escape on the last byte.
  task automatic test_escapes();
    gaps_on    = 1'b0;
    stall_mode = STALL_HEAVY;
    unit_buf = '{8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h01};
    send_unit(1'b1, 1'b1, 1'b0);
    unit_buf = '{8'h41, 8'h11, 8'h00, 8'h00, 8'h02, 8'h33};
    send_unit(1'b1, 1'b1, 1'b1);
  endtask

  // Restart inside an open unit, then a unit that arrives without its first mark.
  task automatic test_restart_and_unmarked();
    gaps_on    = 1'b1;
    stall_mode = STALL_NONE;
    unit_buf = '{8'h21, 8'h00};
    send_unit(1'b1, 1'b0, 1'b1);
    unit_buf = '{8'h25, 8'h80};
    send_unit(1'b1, 1'b1, 1'b0);
    unit_buf = '{8'h09, 8'h00, 8'h00};
    send_unit(1'b0, 1'b1, 1'b1);
  endtask

  // Hold off the output for a long stretch while input keeps coming, so it backs up.
  task automatic test_backpressure();
    int unsigned u;
    int unsigned i;
    wait_stream_drained();
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_req   = 400;
    for (u = 0; u < 6; u++) begin
      unit_buf = {};
      unit_buf.push_back(header_byte());
      for (i = 0; i < 7; i++) unit_buf.push_back(body_byte());
      send_unit(1'b1, 1'b1, 1'($urandom));
    end
    wait_stream_drained();
  endtask

  // Mostly well-formed units with random content; some noise and broken units.
  task automatic test_random_units();
    int unsigned start_count;
    int unsigned kind;
    int unsigned len;
    int unsigned i;
    bit          mark_first;
    bit          with_last;
    start_count = bytes_sent;
    while (bytes_sent - start_count < 400) begin
      if ($urandom_range(0, 7) == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        gaps_on    = 1'($urandom);
      end
      kind       = $urandom_range(0, 99);
      mark_first = 1'b1;
      with_last  = 1'b1;
      unit_buf   = {};
      if (kind < 12) begin
        unit_buf = '{nae_pkg::BYTE_ZERO, nae_pkg::BYTE_ZERO, nae_pkg::BYTE_ZERO,
                     nae_pkg::BYTE_ONE};
        len = $urandom_range(0, 8);
        for (i = 0; i < len; i++) unit_buf.push_back(body_byte());
      end else if (kind < 24) begin
        len = $urandom_range(1, 3);
        for (i = 0; i < len; i++) unit_buf.push_back(body_byte());
      end else if (kind < 30) begin
        // Broken unit: never closed, so the next marked byte restarts.
        len = $urandom_range(1, 6);
        unit_buf.push_back(header_byte());
        for (i = 1; i < len; i++) unit_buf.push_back(body_byte());
        with_last = 1'b0;
      end else if (kind < 36) begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) unit_buf.push_back(8'($urandom));
        mark_first = 1'b0;
      end else begin
        len = $urandom_range(4, 16);
        unit_buf.push_back(header_byte());
        for (i = 1; i < len; i++) unit_buf.push_back(body_byte());
      end
      send_unit(mark_first, with_last, 1'($urandom));
    end
  endtask

  // Run-time limit well above the slowest correct run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    mismatches = 0;
    bytes_sent = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    stall_mode = STALL_NONE;
    hold_req   = 0;
    hold_left  = 0;
    stall_tick = 0;
    clear_unit_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_start_codes();
    test_passthrough();
    test_escapes();
    test_restart_and_unmarked();
    test_backpressure();
    test_random_units();

    wait_stream_drained();
    if (annexb_q.size() != 0)
      report_mismatch("expected bytes never delivered", '0, 16'(annexb_q.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
